@@ rtl/block_rms_level_meter_defines.svh @@
// Assertion macros for the block RMS level meter.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef BLOCK_RMS_LEVEL_METER_DEFINES_SVH
`define BLOCK_RMS_LEVEL_METER_DEFINES_SVH
`ifndef SYNTHESIS
`define BRLM_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("block_rms_level_meter: check failed");
`define BRLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("block_rms_level_meter: sequence check failed");
`else
`define BRLM_ASSERT(label, prop)
`define BRLM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/brlm_pkg.sv @@
// Shared constants and types for the block RMS level meter.
// No dependencies.
package brlm_pkg;

    localparam int BLOCK_SAMPLES = 8192;
    localparam int BLOCK_LOG2    = $clog2(BLOCK_SAMPLES);
    localparam int ACC_W         = 32 + BLOCK_LOG2;
    localparam int CNT_W         = (BLOCK_LOG2 > 0) ? BLOCK_LOG2 : 1;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 16;
    localparam int OFFSET_W = 8;
    localparam int LEVEL_W  = 19;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 2;

    localparam logic [15:0] GAIN_RESET   = 16'd29658;
    localparam logic [7:0]  OFFSET_RESET = 8'd0;

    localparam logic [IDX_W-1:0] CFG_GAIN   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_OFFSET = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_ACC,
        S_GAIN,
        S_MUL,
        S_ROOT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_SQR,
        MUL_GAIN,
        MUL_MEAN
    } t_mul_sel;

endpackage

@@ rtl/block_rms_level_meter.sv @@
// Block RMS level meter with peak hold: top level.
// Depends on brlm_pkg and block_rms_level_meter_defines.svh.
//
// Each sample beat passes through three steps (magnitude, square on the shared
// 32x32 multiplier, accumulate); the input stalls during that time. The beat that
// closes a block of BLOCK_SAMPLES samples also runs these steps: gain squared
// and mean times gain squared on the same multiplier, 32 steps of the
// bit-pair square root, and a last step to round, subtract the offset, clamp and
// update the peak. The result waits in an output register; a closed block is
// held only if the previous result has not yet been taken.
`include "block_rms_level_meter_defines.svh"

module block_rms_level_meter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [brlm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [brlm_pkg::LEVEL_W-1:0]  o_level,
    output logic signed [brlm_pkg::LEVEL_W-1:0]  o_peak_level,
    input  logic                                 i_cfg_we,
    input  logic [brlm_pkg::IDX_W-1:0]           i_cfg_index,
    input  logic [brlm_pkg::CFG_W-1:0]           i_cfg_data
);

    brlm_pkg::t_state r_state, n_state;
    brlm_pkg::t_mul_sel w_mul_sel;

    logic [brlm_pkg::GAIN_W-1:0]   r_gain;
    logic [brlm_pkg::OFFSET_W-1:0] r_offset;
    logic [brlm_pkg::SAMPLE_W-1:0] r_mag;
    logic [63:0]                   r_prod;
    logic [brlm_pkg::ACC_W-1:0]    r_acc;
    logic [brlm_pkg::CNT_W-1:0]    r_count;
    logic [63:0]                   r_rem;
    logic [63:0]                   r_root;
    logic [63:0]                   r_bit;
    logic signed [brlm_pkg::LEVEL_W-1:0] r_level;
    logic signed [brlm_pkg::LEVEL_W-1:0] r_peak;
    logic                          r_out_valid;

    logic        w_accept;
    logic        w_block_end;
    logic        w_out_free;
    logic [31:0] w_mul_a;
    logic [31:0] w_mul_b;
    logic [63:0] w_mul_p;
    logic [63:0] w_trial;
    logic        w_ge;
    logic [32:0] w_round;
    logic signed [21:0] w_diff;
    logic signed [brlm_pkg::LEVEL_W-1:0] w_level;
    logic [brlm_pkg::SAMPLE_W-1:0] w_mag;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_block_end = (r_count == brlm_pkg::CNT_W'(brlm_pkg::BLOCK_SAMPLES - 1));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_mag       = i_sample[brlm_pkg::SAMPLE_W-1] ? (~i_sample + 16'd1) : i_sample;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            brlm_pkg::S_IDLE: begin
                if (i_in_valid) n_state = brlm_pkg::S_SQR;
            end
            brlm_pkg::S_SQR:  n_state = brlm_pkg::S_ACC;
            brlm_pkg::S_ACC: begin
                n_state = w_block_end ? brlm_pkg::S_GAIN : brlm_pkg::S_IDLE;
            end
            brlm_pkg::S_GAIN: n_state = brlm_pkg::S_MUL;
            brlm_pkg::S_MUL:  n_state = brlm_pkg::S_ROOT;
            brlm_pkg::S_ROOT: begin
                if (r_bit == 64'd1) n_state = brlm_pkg::S_DONE;
            end
            brlm_pkg::S_DONE: begin
                if (w_out_free) n_state = brlm_pkg::S_IDLE;
            end
            default: n_state = brlm_pkg::S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_mul_sel  = brlm_pkg::MUL_SQR;
        case (r_state)
            brlm_pkg::S_IDLE: o_in_stall = 1'b0;
            brlm_pkg::S_GAIN: w_mul_sel  = brlm_pkg::MUL_GAIN;
            brlm_pkg::S_MUL:  w_mul_sel  = brlm_pkg::MUL_MEAN;
            default: begin
                o_in_stall = 1'b1;
                w_mul_sel  = brlm_pkg::MUL_SQR;
            end
        endcase
    end

    // shared multiplier
    always_comb begin
        case (w_mul_sel)
            brlm_pkg::MUL_SQR: begin
                w_mul_a = {16'd0, r_mag};
                w_mul_b = {16'd0, r_mag};
            end
            brlm_pkg::MUL_GAIN: begin
                w_mul_a = {16'd0, r_gain};
                w_mul_b = {16'd0, r_gain};
            end
            brlm_pkg::MUL_MEAN: begin
                w_mul_a = r_acc[brlm_pkg::ACC_W-1 -: 32];
                w_mul_b = r_prod[31:0];
            end
            default: begin
                w_mul_a = 32'd0;
                w_mul_b = 32'd0;
            end
        endcase
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    assign w_trial = r_root + r_bit;
    assign w_ge    = (r_rem >= w_trial);

    assign w_round = {1'b0, r_root[31:0]} + 33'd2048;
    assign w_diff  = $signed({1'b0, w_round[32:12]})
                   - $signed({10'd0, r_offset, 4'd0});
    assign w_level = (w_diff > 22'sd262143) ? 19'sh3FFFF : w_diff[brlm_pkg::LEVEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= brlm_pkg::S_IDLE;
            r_gain      <= brlm_pkg::GAIN_RESET;
            r_offset    <= brlm_pkg::OFFSET_RESET;
            r_acc       <= '0;
            r_count     <= '0;
            r_peak      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    brlm_pkg::CFG_GAIN:   r_gain   <= i_cfg_data;
                    brlm_pkg::CFG_OFFSET: r_offset <= i_cfg_data[brlm_pkg::OFFSET_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == brlm_pkg::S_ACC) begin
                r_acc   <= r_acc + brlm_pkg::ACC_W'(r_prod[31:0]);
                r_count <= w_block_end ? '0 : r_count + 1'b1;
            end
            if (r_state == brlm_pkg::S_DONE && w_out_free) begin
                r_acc       <= '0;
                r_out_valid <= 1'b1;
                if (w_level > r_peak) r_peak <= w_level;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_mag <= w_mag;
        if (r_state == brlm_pkg::S_SQR || r_state == brlm_pkg::S_GAIN) r_prod <= w_mul_p;
        if (r_state == brlm_pkg::S_MUL) begin
            r_rem  <= w_mul_p;
            r_root <= '0;
            r_bit  <= 64'd1 << 62;
        end
        if (r_state == brlm_pkg::S_ROOT) begin
            r_rem  <= w_ge ? (r_rem - w_trial) : r_rem;
            r_root <= w_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);
            r_bit  <= r_bit >> 2;
        end
        if (r_state == brlm_pkg::S_DONE && w_out_free) r_level <= w_level;
    end

    assign o_out_valid  = r_out_valid;
    assign o_level      = r_level;
    assign o_peak_level = r_peak;

    `BRLM_ASSERT_NEXT(a_accept_to_square, w_accept, r_state == brlm_pkg::S_SQR)
    `BRLM_ASSERT_NEXT(a_root_ends, r_state == brlm_pkg::S_ROOT && r_bit == 64'd1, r_state == brlm_pkg::S_DONE)
    `BRLM_ASSERT(a_result_from_done, $rose(r_out_valid) |-> $past(r_state == brlm_pkg::S_DONE))
    `BRLM_ASSERT(a_peak_not_negative, !r_peak[brlm_pkg::LEVEL_W-1])

endmodule

@@ test/block_rms_level_meter_checker.sv @@
`timescale 1ns / 100ps
// Checker for the block RMS level meter: watches the sample, result and register ports,
// predicts each block's level and peak hold, and compares every result beat.
// Depends on brlm_pkg.
module block_rms_level_meter_checker
    import brlm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [LEVEL_W-1:0]  i_level,
    input  logic signed [LEVEL_W-1:0]  i_peak_level,
    input  logic                       i_cfg_we,
    input  logic [IDX_W-1:0]           i_cfg_index,
    input  logic [CFG_W-1:0]           i_cfg_data,
    output int                         o_mismatches,
    output int                         o_outstanding
);

    localparam int LEVEL_TOP = 2 ** (LEVEL_W - 1) - 1;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic signed [LEVEL_W-1:0] peak;
    } t_reading;

    t_reading            readings_due[$];
    logic [GAIN_W-1:0]   gain_q;
    logic [OFFSET_W-1:0] offset_q;
    logic [63:0]         energy_acc;
    int unsigned         samples_seen;
    int                  peak_q;
    int                  fails = 0;

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic int block_level(input logic [63:0] sum, input logic [GAIN_W-1:0] gain,
                                       input logic [OFFSET_W-1:0] offset);
        logic [63:0] mean_sq;
        logic [63:0] weighted;
        logic [63:0] rounded;
        int          lvl;
        mean_sq  = sum / 64'(BLOCK_SAMPLES);
        weighted = mean_sq * 64'(gain) * 64'(gain);
        rounded  = (floor_sqrt(weighted) + 64'd2048) >> 12;
        lvl      = int'(rounded) - int'({offset, 4'b0000});
        if (lvl > LEVEL_TOP) begin
            lvl = LEVEL_TOP;
        end
        return lvl;
    endfunction

    always @(posedge i_clk) begin
        t_reading    want;
        int unsigned mag;
        int          lvl;
        if (!i_rst_n) begin
            gain_q       = GAIN_RESET;
            offset_q     = OFFSET_RESET;
            energy_acc   = '0;
            samples_seen = 0;
            peak_q       = 0;
            readings_due.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (readings_due.size() == 0) begin
                    $error("unexpected result beat: level %0d peak_level %0d",
                           i_level, i_peak_level);
                    fails++;
                end else begin
                    want = readings_due.pop_front();
                    if (i_level !== want.level) begin
                        $error("level: expected %0d, got %0d", want.level, i_level);
                        fails++;
                    end
                    if (i_peak_level !== want.peak) begin
                        $error("peak_level: expected %0d, got %0d", want.peak, i_peak_level);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                mag          = (i_sample < 0) ? -int'(i_sample) : int'(i_sample);
                energy_acc   = energy_acc + 64'(mag * mag);
                samples_seen = samples_seen + 1;
                if (samples_seen == BLOCK_SAMPLES) begin
                    lvl = block_level(energy_acc, gain_q, offset_q);
                    if (lvl > peak_q) begin
                        peak_q = lvl;
                    end
                    want.level = lvl[LEVEL_W-1:0];
                    want.peak  = peak_q[LEVEL_W-1:0];
                    readings_due.push_back(want);
                    energy_acc   = '0;
                    samples_seen = 0;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GAIN: begin
                        gain_q = i_cfg_data[GAIN_W-1:0];
                    end
                    CFG_OFFSET: begin
                        offset_q = i_cfg_data[OFFSET_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_mismatches  <= fails;
        o_outstanding <= readings_due.size();
    end

endmodule

@@ test/block_rms_level_meter_tb.sv @@
`timescale 1ns / 100ps
// Top of the block RMS level meter testbench: clock, reset, sample stimulus, register
// writes and result-side stalls; the checker module judges every result beat.
// Depends on brlm_pkg, block_rms_level_meter and block_rms_level_meter_checker.
module block_rms_level_meter_tb;
    import brlm_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int IDLE_PERCENT   = 9;
    localparam int BACKLOG_CYCLES = 70000;
    localparam int SETTLE_CYCLES  = 64;
    localparam int QUIET_LIMIT    = 200000;
    localparam int RANDOM_PHASES  = 18;
    localparam int BACKLOG_PHASE  = 4;
    localparam int STEADY_PHASE   = 9;

    localparam logic [IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef enum logic [1:0] {
        FILL_CONST,
        FILL_ALT,
        FILL_UNIFORM,
        FILL_SCALED
    } t_fill;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [LEVEL_W-1:0]  level;
    logic signed [LEVEL_W-1:0]  peak_level;
    logic                       cfg_we = 1'b0;
    logic [IDX_W-1:0]           cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;
    int                         mismatches;
    int                         readings_left;
    bit                         steady = 1'b0;
    bit                         backlog_req = 1'b0;
    int                         quiet_cycles = 0;

    always #(HALF_PERIOD) clk = ~clk;

    block_rms_level_meter i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_sample     (sample),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_level      (level),
        .o_peak_level (peak_level),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    block_rms_level_meter_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_sample      (sample),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_level       (level),
        .i_peak_level  (peak_level),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (readings_left)
    );

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_beat(input logic signed [SAMPLE_W-1:0] value);
        if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_block(input t_fill fill, input int param);
        logic signed [SAMPLE_W-1:0] value;
        logic signed [SAMPLE_W-1:0] draw;
        for (int n = 0; n < BLOCK_SAMPLES; n++) begin
            draw = SAMPLE_W'($urandom);
            case (fill)
                FILL_CONST: begin
                    value = SAMPLE_W'(param);
                end
                FILL_ALT: begin
                    value = SAMPLE_W'(n[0] ? -param : param);
                end
                FILL_UNIFORM: begin
                    value = draw;
                end
                default: begin
                    value = draw >>> param;
                end
            endcase
            send_beat(value);
        end
    endtask

    // Drain, then reprogram while the meter is idle and stream whole blocks.
    task automatic run_phase(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] offset_word,
                             input int blocks, input t_fill fill, input int param,
                             input bit backlog, input bit steady_run);
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_left != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_OFFSET, offset_word);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_W'($urandom));
        steady = steady_run;
        if (backlog) begin
            backlog_req = 1'b1;
        end
        repeat (blocks) send_block(fill, param);
    endtask

    // Result side: random stalls, or one long hold-off on request.
    initial begin
        forever begin
            @(posedge clk);
            if (backlog_req) begin
                backlog_req = 1'b0;
                out_stall <= 1'b1;
                repeat (BACKLOG_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("block_rms_level_meter_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [CFG_W-1:0]           gain;
        logic [CFG_W-1:0]           offset_word;
        t_fill                      fill;
        int                         param;
        logic signed [SAMPLE_W-1:0] draw;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // silence, negative level with a masked offset, peak rise and hold, floor level
        run_phase(CFG_W'(GAIN_RESET), CFG_W'(OFFSET_RESET), 1, FILL_CONST, 0, 1'b0, 1'b0);
        run_phase(CFG_W'(GAIN_RESET), 16'h01F0, 1, FILL_ALT, 1, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'h0000, 1, FILL_ALT, 1000, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'h0000, 1, FILL_CONST, -500, 1'b0, 1'b0);
        run_phase(16'h0000, 16'h00FF, 1, FILL_CONST, 32767, 1'b0, 1'b0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0: gain = 16'h0000;
                1: gain = 16'hFFFF;
                default: gain = CFG_W'($urandom_range(1, 65534));
            endcase
            offset_word = $urandom_range(0, 1) ? CFG_W'($urandom_range(0, 65535))
                                               : CFG_W'($urandom_range(0, 31));
            fill = t_fill'($urandom_range(0, 3));
            // keep levels below saturation so the peak hold keeps moving
            if (fill == FILL_UNIFORM && gain > 50000) begin
                fill = FILL_SCALED;
            end
            case (fill)
                FILL_UNIFORM: begin
                    param = 0;
                end
                FILL_SCALED: begin
                    param = $urandom_range(1, 14);
                end
                default: begin
                    draw  = SAMPLE_W'($urandom);
                    param = int'(draw) >>> $urandom_range(gain > 32000 ? 2 : 0, 14);
                end
            endcase
            run_phase(gain, offset_word,
                      (p == BACKLOG_PHASE) ? 3 : ((p == STEADY_PHASE) ? 2 : 1),
                      fill, param, p == BACKLOG_PHASE, p == STEADY_PHASE);
        end

        // full-scale input at top gain: level clamps
        run_phase(16'hFFFF, 16'h0000, 1, FILL_CONST, -32768, 1'b0, 1'b0);
        run_phase(16'hFFFF, 16'h0000, 1, FILL_ALT, 32767, 1'b0, 1'b0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_left != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("block_rms_level_meter_tb: PASS");
        end else begin
            $display("block_rms_level_meter_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ block_rms_level_meter.f @@
+incdir+rtl
rtl/brlm_pkg.sv
rtl/block_rms_level_meter.sv
test/block_rms_level_meter_checker.sv
test/block_rms_level_meter_tb.sv
